[hw/rtl/cause_effect_chain_latency_monitor_defines.svh]
// Assertion macros for the cause-effect chain latency monitor checkers.
`ifndef CAUSE_EFFECT_CHAIN_LATENCY_MONITOR_DEFINES_SVH
`define CAUSE_EFFECT_CHAIN_LATENCY_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CECL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CECL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cecl_pkg.sv]
// Shared constants of the cause-effect chain latency monitor.
package cecl_pkg;

    localparam int TASK_W    = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_TASK_IDS = 1'b1;

    localparam logic [1:0] ST_UNREAD  = 2'd0;
    localparam logic [1:0] ST_READ    = 2'd1;
    localparam logic [1:0] ST_WRITTEN = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic KIND_AGE      = 1'b0;
    localparam logic KIND_REACTION = 1'b1;

endpackage

[hw/rtl/cause_effect_chain_latency_monitor.sv]
// Top level of the cause-effect chain latency monitor.
//
// channel   direction  handshake                     payload
// event     in         start & !busy                 operation, task_id, time_stamp
// result    out        result_valid (one cycle)      kind, latency, last
// config    in         cfg_write                     cfg_index, cfg_data
//
// An event goes from S_IDLE through S_POS for each chain position in use to
// S_DONE; a sweep or scan of the sample table passes S_RD and S_EV per live
// sample, the scan also S_EV2 for the sample that yields both an age and a
// reaction result. The status and start memories are read and rewritten one
// slot at a time. Reset clears the sample count; no clearing pass is needed.
// Results cannot be stalled; busy is high from acceptance to the final result.
module cause_effect_chain_latency_monitor #(
    parameter int SAMPLE_DEPTH = 16,
    parameter int MAX_CHAIN    = 8,
    parameter int TIME_WIDTH   = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               operation,
    input  logic [cecl_pkg::TASK_W-1:0]        task_id,
    input  logic [TIME_WIDTH-1:0]              time_stamp,
    input  logic                               cfg_write,
    input  logic [cecl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cecl_pkg::CFG_W-1:0]         cfg_data,
    output logic                               result_valid,
    output logic                               kind,
    output logic [TIME_WIDTH-1:0]              latency,
    output logic                               last
);

    localparam int SLOT_W = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int POS_W  = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int STAT_W = 2 * MAX_CHAIN;
    localparam int LEN_W  = cecl_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_RD,
        S_EV,
        S_EV2,
        S_DONE
    } state_t;

    logic [TIME_WIDTH-1:0] start_mem [SAMPLE_DEPTH];
    logic [STAT_W-1:0]     stat_mem  [SAMPLE_DEPTH];

    state_t                     state_reg, state_next;
    logic                       busy_reg, busy_next;
    logic [POS_W-1:0]           p_reg, p_next;
    logic                       op_reg, op_next;
    logic [cecl_pkg::TASK_W-1:0] task_reg, task_next;
    logic [TIME_WIDTH-1:0]      now_reg, now_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [SLOT_W-1:0]          cur_slot_reg, cur_slot_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic                       found_reg, found_next;
    logic [CNT_W-1:0]           keep_reg, keep_next;
    logic [SLOT_W-1:0]          keep_slot_reg, keep_slot_next;
    logic [SLOT_W-1:0]          oldest_reg, oldest_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       pend_kind_reg, pend_kind_next;
    logic [TIME_WIDTH-1:0]      pend_lat_reg, pend_lat_next;
    logic [TIME_WIDTH-1:0]      lat_hold_reg, lat_hold_next;
    logic                       result_valid_reg, result_valid_next;
    logic                       kind_reg, kind_next;
    logic [TIME_WIDTH-1:0]      latency_reg, latency_next;
    logic                       last_reg, last_next;
    logic [LEN_W-1:0]           chain_length_reg, chain_length_next;
    logic [cecl_pkg::CFG_W-1:0] chain_ids_reg, chain_ids_next;

    logic [STAT_W-1:0]          stat_rd_reg;
    logic [TIME_WIDTH-1:0]      start_rd_reg;

    logic                       mem_stat_we;
    logic                       mem_start_we;
    logic [SLOT_W-1:0]          mem_wr_addr;
    logic [STAT_W-1:0]          mem_stat_wdata;

    logic                       pos_last;
    logic                       scan_mode;
    logic [POS_W-1:0]           p_prev;
    logic [1:0]                 st_cur;
    logic [1:0]                 st_prev;
    logic [TIME_WIDTH-1:0]      lat_now;
    logic [cecl_pkg::TASK_W-1:0] pos_task;
    logic [CNT_W-1:0]           open_cnt;
    logic [SLOT_W-1:0]          open_oldest;

    logic                       push_req;
    logic                       push_kind;
    logic [TIME_WIDTH-1:0]      push_lat;
    logic                       scan_step;
    logic                       pos_advance;

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(SAMPLE_DEPTH))
        begin
            s = s - (SLOT_W+1)'(SAMPLE_DEPTH);
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
        return (a == SLOT_W'(SAMPLE_DEPTH - 1)) ? '0 : a + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] a);
        return (a == '0) ? SLOT_W'(SAMPLE_DEPTH - 1) : a - SLOT_W'(1);
    endfunction

    assign pos_last  = (LEN_W'(p_reg) == len_reg - LEN_W'(1));
    assign scan_mode = (op_reg == cecl_pkg::OP_WRITE) && pos_last;
    assign p_prev    = p_reg - POS_W'(1);
    assign st_cur    = stat_rd_reg[2*p_reg +: 2];
    assign st_prev   = stat_rd_reg[2*p_prev +: 2];
    assign lat_now   = now_reg - start_rd_reg;
    assign pos_task  = chain_ids_reg[cecl_pkg::TASK_W*p_reg +: cecl_pkg::TASK_W];

    always_comb
    begin
        open_oldest = oldest_reg;
        open_cnt    = count_reg;
        if (count_reg == CNT_W'(SAMPLE_DEPTH))
        begin
            open_oldest = slot_inc(oldest_reg);
            open_cnt    = CNT_W'(SAMPLE_DEPTH - 1);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        busy_next         = busy_reg;
        p_next            = p_reg;
        op_next           = op_reg;
        task_next         = task_reg;
        now_next          = now_reg;
        len_next          = len_reg;
        cur_slot_next     = cur_slot_reg;
        k_next            = k_reg;
        found_next        = found_reg;
        keep_next         = keep_reg;
        keep_slot_next    = keep_slot_reg;
        oldest_next       = oldest_reg;
        count_next        = count_reg;
        pend_valid_next   = pend_valid_reg;
        pend_kind_next    = pend_kind_reg;
        pend_lat_next     = pend_lat_reg;
        lat_hold_next     = lat_hold_reg;
        result_valid_next = 1'b0;
        kind_next         = kind_reg;
        latency_next      = latency_reg;
        last_next         = last_reg;
        chain_length_next = chain_length_reg;
        chain_ids_next    = chain_ids_reg;

        mem_stat_we    = 1'b0;
        mem_start_we   = 1'b0;
        mem_wr_addr    = cur_slot_reg;
        mem_stat_wdata = stat_rd_reg;

        push_req    = 1'b0;
        push_kind   = cecl_pkg::KIND_AGE;
        push_lat    = lat_now;
        scan_step   = 1'b0;
        pos_advance = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                cecl_pkg::REG_CHAIN_LENGTH:   chain_length_next = cfg_data[LEN_W-1:0];
                cecl_pkg::REG_CHAIN_TASK_IDS: chain_ids_next    = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    busy_next = 1'b1;
                    op_next   = operation;
                    task_next = task_id;
                    now_next  = time_stamp;
                    p_next    = '0;
                    if (chain_length_reg > LEN_W'(MAX_CHAIN))
                    begin
                        len_next = LEN_W'(MAX_CHAIN);
                    end
                    else
                    begin
                        len_next = chain_length_reg;
                    end
                    state_next = (chain_length_reg == '0) ? S_DONE : S_POS;
                end
            end

            S_POS:
            begin
                if (pos_task != task_reg)
                begin
                    pos_advance = 1'b1;
                end
                else if (op_reg == cecl_pkg::OP_READ && p_reg == '0)
                begin
                    mem_stat_we    = 1'b1;
                    mem_start_we   = 1'b1;
                    mem_wr_addr    = slot_add(open_oldest, SLOT_W'(open_cnt));
                    mem_stat_wdata = STAT_W'(cecl_pkg::ST_READ);
                    oldest_next    = open_oldest;
                    count_next     = open_cnt + CNT_W'(1);
                    pos_advance    = 1'b1;
                end
                else if (count_reg == '0)
                begin
                    pos_advance = 1'b1;
                end
                else if (scan_mode)
                begin
                    cur_slot_next = slot_add(oldest_reg, SLOT_W'(count_reg - CNT_W'(1)));
                    k_next        = count_reg;
                    found_next    = 1'b0;
                    keep_next     = '0;
                    state_next    = S_RD;
                end
                else
                begin
                    cur_slot_next = oldest_reg;
                    k_next        = '0;
                    state_next    = S_RD;
                end
            end

            S_RD:
            begin
                state_next = S_EV;
            end

            S_EV:
            begin
                if (scan_mode)
                begin
                    scan_step = 1'b1;
                    if (st_cur != cecl_pkg::ST_UNREAD)
                    begin
                        mem_stat_we                  = 1'b1;
                        mem_stat_wdata[2*p_reg +: 2] = cecl_pkg::ST_WRITTEN;
                        if (!found_reg)
                        begin
                            push_req       = 1'b1;
                            push_kind      = cecl_pkg::KIND_AGE;
                            found_next     = 1'b1;
                            keep_next      = k_reg - CNT_W'(1);
                            keep_slot_next = cur_slot_reg;
                            if (st_cur == cecl_pkg::ST_READ)
                            begin
                                lat_hold_next = lat_now;
                                scan_step     = 1'b0;
                                state_next    = S_EV2;
                            end
                        end
                        else if (st_cur == cecl_pkg::ST_READ)
                        begin
                            push_req  = 1'b1;
                            push_kind = cecl_pkg::KIND_REACTION;
                        end
                    end
                end
                else
                begin
                    mem_stat_we = 1'b1;
                    if (op_reg == cecl_pkg::OP_READ)
                    begin
                        if (st_prev == cecl_pkg::ST_WRITTEN && st_cur == cecl_pkg::ST_UNREAD)
                        begin
                            mem_stat_wdata[2*p_reg +: 2] = cecl_pkg::ST_READ;
                        end
                    end
                    else if (st_cur == cecl_pkg::ST_READ)
                    begin
                        mem_stat_wdata[2*p_reg +: 2] = cecl_pkg::ST_WRITTEN;
                    end
                    if (k_reg + CNT_W'(1) == count_reg)
                    begin
                        pos_advance = 1'b1;
                    end
                    else
                    begin
                        cur_slot_next = slot_inc(cur_slot_reg);
                        k_next        = k_reg + CNT_W'(1);
                        state_next    = S_RD;
                    end
                end
            end

            S_EV2:
            begin
                push_req  = 1'b1;
                push_kind = cecl_pkg::KIND_REACTION;
                push_lat  = lat_hold_reg;
                scan_step = 1'b1;
            end

            S_DONE:
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next = 1'b1;
                    kind_next         = pend_kind_reg;
                    latency_next      = pend_lat_reg;
                    last_next         = 1'b1;
                    pend_valid_next   = 1'b0;
                end
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (scan_step)
        begin
            if (k_reg == CNT_W'(1))
            begin
                if (found_next)
                begin
                    oldest_next = keep_slot_next;
                    count_next  = count_reg - keep_next;
                end
                state_next = S_DONE;
            end
            else
            begin
                cur_slot_next = slot_dec(cur_slot_reg);
                k_next        = k_reg - CNT_W'(1);
                state_next    = S_RD;
            end
        end

        if (pos_advance)
        begin
            if (pos_last)
            begin
                state_next = S_DONE;
            end
            else
            begin
                p_next     = p_reg + POS_W'(1);
                state_next = S_POS;
            end
        end

        if (push_req)
        begin
            if (pend_valid_reg)
            begin
                result_valid_next = 1'b1;
                kind_next         = pend_kind_reg;
                latency_next      = pend_lat_reg;
                last_next         = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = push_kind;
            pend_lat_next   = push_lat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_stat_we)
        begin
            stat_mem[mem_wr_addr] <= mem_stat_wdata;
        end
        if (mem_start_we)
        begin
            start_mem[mem_wr_addr] <= now_reg;
        end
        stat_rd_reg  <= stat_mem[cur_slot_reg];
        start_rd_reg <= start_mem[cur_slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            busy_reg         <= 1'b0;
            oldest_reg       <= '0;
            count_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            chain_length_reg <= LEN_W'(1);
            chain_ids_reg    <= '0;
            p_reg            <= '0;
            found_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            busy_reg         <= busy_next;
            oldest_reg       <= oldest_next;
            count_reg        <= count_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            chain_length_reg <= chain_length_next;
            chain_ids_reg    <= chain_ids_next;
            p_reg            <= p_next;
            found_reg        <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        task_reg      <= task_next;
        now_reg       <= now_next;
        len_reg       <= len_next;
        cur_slot_reg  <= cur_slot_next;
        k_reg         <= k_next;
        keep_reg      <= keep_next;
        keep_slot_reg <= keep_slot_next;
        pend_kind_reg <= pend_kind_next;
        pend_lat_reg  <= pend_lat_next;
        lat_hold_reg  <= lat_hold_next;
        kind_reg      <= kind_next;
        latency_reg   <= latency_next;
        last_reg      <= last_next;
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign latency      = latency_reg;
    assign last         = last_reg;

endmodule

[hw/rtl/cecl_checker.sv]
// Port-level checker of the cause-effect chain latency monitor and its bind.
`include "cause_effect_chain_latency_monitor_defines.svh"

module cecl_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic last
);

    `CECL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `CECL_ASSERT_NOW(a_result_in_event, result_valid, $past(busy), "result outside a transaction")
    `CECL_ASSERT_NOW(a_mid_result_busy, result_valid && !last, busy, "busy dropped before last result")
    `CECL_ASSERT_NOW(a_last_ends_event, result_valid && last, !busy, "last result while still busy")

endmodule

bind cause_effect_chain_latency_monitor cecl_checker u_cecl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .last         (last)
);
